// ===== rtl/mu7_pkg.sv =====
// Shared types, character codes and the base64 alphabet for the modified UTF-7 encoder.
package mu7_pkg;

  localparam logic [6:0] CH_AMP        = 7'h26;
  localparam logic [6:0] CH_DASH       = 7'h2D;
  localparam logic [6:0] CH_UNDERSCORE = 7'h5F;
  localparam logic [6:0] CH_UPPER_A    = 7'h41;
  localparam logic [6:0] CH_LOWER_A    = 7'h61;
  localparam logic [6:0] CH_DIGIT_0    = 7'h30;
  localparam logic [6:0] CH_PLUS       = 7'h2B;
  localparam logic [6:0] CH_COMMA      = 7'h2C;

  localparam logic [7:0] BYTE_SPACE      = 8'h20;
  localparam logic [7:0] BYTE_TILDE      = 8'h7E;
  localparam logic [7:0] BYTE_UNDERSCORE = 8'h5F;
  localparam logic [7:0] BYTE_HIGH       = 8'h80;
  localparam logic [7:0] BYTE_LEAD3      = 8'hE0;
  localparam logic [7:0] BYTE_LEAD4      = 8'hF0;

  localparam logic [20:0] CP_SUPPLEMENTARY = 21'h10000;
  localparam logic [15:0] SURR_HIGH_BASE   = 16'hD800;
  localparam logic [5:0]  SURR_LOW_TAG     = 6'b110111;

  typedef enum logic [1:0] {
    CMD_PRINT = 2'd0,
    CMD_ENC   = 2'd1,
    CMD_END   = 2'd2
  } cmd_kind_t;

  // One classified input item, handed from the front end to the emitter.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [6:0]  chr;
    logic [1:0]  nunits;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } cmd_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] w;
    w = {1'b0, v};
    if (v < 6'd26) begin
      return CH_UPPER_A + w;
    end else if (v < 6'd52) begin
      return CH_LOWER_A + w - 7'd26;
    end else if (v < 6'd62) begin
      return CH_DIGIT_0 + w - 7'd52;
    end else if (v == 6'd62) begin
      return CH_PLUS;
    end else begin
      return CH_COMMA;
    end
  endfunction

endpackage

// ===== rtl/mu7_front.sv =====
// Front end: accepts input bytes, assembles UTF-8 code points and classifies each item.
module mu7_front
  import mu7_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [0:0] in_tuser,
  input  logic       space_to_underscore,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [2:0]  utf8_total_r, utf8_total_nxt;
  logic [2:0]  utf8_count_r, utf8_count_nxt;
  logic [20:0] code_point_r, code_point_nxt;

  logic [7:0]  c;
  logic        printable;
  logic        complete;
  logic [2:0]  count_inc;
  logic [20:0] cp_off;

  assign c         = in_tdata;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign count_inc = utf8_count_r + 3'd1;
  assign printable = (c >= BYTE_SPACE) && (c <= BYTE_TILDE) &&
                     !((c == BYTE_UNDERSCORE) && space_to_underscore);

  always_comb begin
    utf8_total_nxt = utf8_total_r;
    utf8_count_nxt = utf8_count_r;
    code_point_nxt = code_point_r;
    complete       = 1'b0;
    cp_off         = '0;
    q_cmd          = '0;
    q_cmd.kind     = CMD_END;

    if (in_tuser[0]) begin
      q_cmd.kind     = CMD_END;
      utf8_total_nxt = '0;
      utf8_count_nxt = '0;
      code_point_nxt = '0;
    end else if (printable) begin
      q_cmd.kind = CMD_PRINT;
      q_cmd.chr  = (space_to_underscore && (c == BYTE_SPACE)) ? CH_UNDERSCORE : c[6:0];
      // Leaving base64 mode always drops a partial sequence.
      utf8_total_nxt = '0;
      utf8_count_nxt = '0;
    end else begin
      q_cmd.kind = CMD_ENC;
      if (c < BYTE_HIGH) begin
        code_point_nxt = {13'd0, c};
        complete       = 1'b1;
      end else if (utf8_total_r != 3'd0) begin
        code_point_nxt = {code_point_r[14:0], c[5:0]};
        utf8_count_nxt = count_inc;
        complete       = !(count_inc < utf8_total_r);
      end else begin
        // Any byte that opens a sequence here, stray continuations included.
        utf8_count_nxt = 3'd1;
        if (c < BYTE_LEAD3) begin
          utf8_total_nxt = 3'd2;
          code_point_nxt = {16'd0, c[4:0]};
        end else if (c < BYTE_LEAD4) begin
          utf8_total_nxt = 3'd3;
          code_point_nxt = {17'd0, c[3:0]};
        end else begin
          utf8_total_nxt = 3'd4;
          code_point_nxt = {18'd0, c[2:0]};
        end
      end
      if (complete) begin
        utf8_total_nxt = '0;
        cp_off         = code_point_nxt - CP_SUPPLEMENTARY;
        if (code_point_nxt >= CP_SUPPLEMENTARY) begin
          q_cmd.nunits = 2'd2;
          q_cmd.unit0  = 16'(cp_off[20:10]) + SURR_HIGH_BASE;
          q_cmd.unit1  = {SURR_LOW_TAG, cp_off[9:0]};
        end else begin
          q_cmd.nunits = 2'd1;
          q_cmd.unit0  = code_point_nxt[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf8_total_r <= '0;
      utf8_count_r <= '0;
      code_point_r <= '0;
    end else if (q_push) begin
      utf8_total_r <= utf8_total_nxt;
      utf8_count_r <= utf8_count_nxt;
      code_point_r <= code_point_nxt;
    end
  end

endmodule

// ===== rtl/mu7_fifo.sv =====
// Short command queue between the front end and the character emitter.
module mu7_fifo
  import mu7_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/mu7_back.sv =====
// Emitter: runs queued commands, keeps base64 mode and the bit buffer, drives one character a beat.
module mu7_back
  import mu7_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [6:0] out_char,
  output logic       out_tlast
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_FLUSH   = 7'b0000010,
    ST_DASH    = 7'b0000100,
    ST_CHAR    = 7'b0001000,
    ST_AMPDASH = 7'b0010000,
    ST_OPEN    = 7'b0100000,
    ST_SEXT    = 7'b1000000
  } st_t;

  st_t         st_r, st_nxt, st_act;
  cmd_t        cmd_r, cmd_nxt;
  logic        shift_r, shift_nxt, shift_act;
  logic [19:0] buf_r, buf_nxt, buf_act;
  logic [4:0]  pend_r, pend_nxt, pend_act;
  logic        more_r, more_nxt, more_act;
  logic        out_valid_r;
  logic [6:0]  out_char_r;
  logic        out_last_r;

  logic        fire;
  logic        done;
  logic [6:0]  emit_char;
  logic [4:0]  pend_dec;
  logic [5:0]  flush_sext;

  assign fire       = (st_r != ST_IDLE) && (!out_valid_r || out_tready);
  assign pend_dec   = pend_r - 5'd6;
  assign flush_sext = 6'(buf_r[5:0] << (5'd6 - pend_r));

  always_comb begin
    st_act    = st_r;
    shift_act = shift_r;
    buf_act   = buf_r;
    pend_act  = pend_r;
    more_act  = more_r;
    emit_char = '0;
    done      = 1'b0;

    if (fire) begin
      unique case (st_r)
        ST_FLUSH: begin
          emit_char = b64_char(flush_sext);
          pend_act  = '0;
          st_act    = ST_DASH;
        end
        ST_DASH: begin
          emit_char = CH_DASH;
          shift_act = 1'b0;
          pend_act  = '0;
          if (cmd_r.kind == CMD_END) begin
            buf_act = '0;
            done    = 1'b1;
          end else begin
            st_act = ST_CHAR;
          end
        end
        ST_CHAR: begin
          emit_char = cmd_r.chr;
          if (cmd_r.chr == CH_AMP) begin
            st_act = ST_AMPDASH;
          end else begin
            done = 1'b1;
          end
        end
        ST_AMPDASH: begin
          emit_char = CH_DASH;
          done      = 1'b1;
        end
        ST_OPEN: begin
          emit_char = CH_AMP;
          shift_act = 1'b1;
          if (cmd_r.nunits != 2'd0) begin
            buf_act  = {buf_r[3:0], cmd_r.unit0};
            pend_act = pend_r + 5'd16;
            more_act = (cmd_r.nunits == 2'd2);
            st_act   = ST_SEXT;
          end else begin
            done = 1'b1;
          end
        end
        ST_SEXT: begin
          emit_char = b64_char(6'(buf_r >> pend_dec));
          pend_act  = pend_dec;
          if (pend_dec >= 5'd6) begin
            st_act = ST_SEXT;
          end else if (more_r) begin
            buf_act  = {buf_r[3:0], cmd_r.unit1};
            pend_act = pend_dec + 5'd16;
            more_act = 1'b0;
          end else begin
            done = 1'b1;
          end
        end
        default: begin
          st_act = st_r;
        end
      endcase
    end
    if (done) begin
      st_act = ST_IDLE;
    end
  end

  // The next command starts in the same cycle the current one emits its final beat.
  always_comb begin
    st_nxt    = st_act;
    shift_nxt = shift_act;
    buf_nxt   = buf_act;
    pend_nxt  = pend_act;
    more_nxt  = more_act;
    cmd_nxt   = cmd_r;
    q_pop     = (st_act == ST_IDLE) && q_valid;

    if (q_pop) begin
      cmd_nxt = q_cmd;
      case (q_cmd.kind)
        CMD_PRINT: begin
          if (shift_act) begin
            st_nxt = (pend_act != 5'd0) ? ST_FLUSH : ST_DASH;
          end else begin
            st_nxt = ST_CHAR;
          end
        end
        CMD_ENC: begin
          if (!shift_act) begin
            st_nxt = ST_OPEN;
          end else if (q_cmd.nunits != 2'd0) begin
            buf_nxt  = {buf_act[3:0], q_cmd.unit0};
            pend_nxt = pend_act + 5'd16;
            more_nxt = (q_cmd.nunits == 2'd2);
            st_nxt   = ST_SEXT;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
        default: begin
          // End of string: close base64 mode if open, otherwise just clear.
          if (shift_act) begin
            st_nxt = (pend_act != 5'd0) ? ST_FLUSH : ST_DASH;
          end else begin
            st_nxt    = ST_IDLE;
            shift_nxt = 1'b0;
            buf_nxt   = '0;
            pend_nxt  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      shift_r     <= 1'b0;
      buf_r       <= '0;
      pend_r      <= '0;
      more_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      shift_r <= shift_nxt;
      buf_r   <= buf_nxt;
      pend_r  <= pend_nxt;
      more_r  <= more_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (fire) begin
      out_char_r <= emit_char;
      out_last_r <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/modified_utf7_encoder.sv =====
// Top level of the modified UTF-7 encoder: front end, command queue and character emitter.
// An item's first character passes through the command queue, the emitter state register and the output register.
// Throughput: the emitter drives one character per cycle unless the output stalls; an item yields
// one to six characters, or none at all.
// The input is held off only while the command queue is full.
// Reset (synchronous, rst_n low) returns to direct mode, empties the queue, clears space mapping.
module modified_utf7_encoder
  import mu7_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0] in_tuser,   // [0] end_of_string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic       out_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic       space_to_underscore_r;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  cmd_t       push_cmd;
  cmd_t       pop_cmd;
  logic [6:0] out_char;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_to_underscore_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      space_to_underscore_r <= cfg_data;
    end
  end

  mu7_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .in_tuser            (in_tuser),
    .space_to_underscore (space_to_underscore_r),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_cmd               (push_cmd)
  );

  mu7_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .valid    (q_valid)
  );

  mu7_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_char),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

  a_reset_clears_output: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output beat valid right after reset");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");

endmodule

// ===== tb/modified_utf7_encoder_test.sv =====
// Self-checking testbench for the modified UTF-7 encoder with random gaps on both streams.
module modified_utf7_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mu7_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 20;
  localparam int MAX_CHARS     = 6;
  localparam logic [15:0] SURR_LOW_BASE = 16'hDC00;

  typedef struct packed {
    logic [6:0] ch;
    logic       fin;
  } enc_char_t;

  // Tracks the encoder state and holds the characters it still owes.
  class utf7_checker;
    bit          spaces;
    bit          shifted;
    logic [19:0] bits;
    logic [4:0]  nbits;
    logic [2:0]  seq_len;
    logic [2:0]  seq_pos;
    logic [20:0] cp;
    enc_char_t   owed_q[$];
    logic [6:0]  step_chars[$];
    int          failures;

    function new();
      spaces   = 0;
      failures = 0;
      clear_state();
    endfunction

    function void clear_state();
      shifted = 0;
      bits    = '0;
      nbits   = '0;
      seq_len = '0;
      seq_pos = '0;
      cp      = '0;
    endfunction

    function int waiting();
      return owed_q.size();
    endfunction

    function void put(logic [6:0] ch);
      if (step_chars.size() < MAX_CHARS) step_chars.push_back(ch);
    endfunction

    function logic [6:0] sextet_char(logic [5:0] v);
      string alphabet;
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+,";
      return 7'(alphabet[v]);
    endfunction

    function void close_run();
      logic [19:0] t;
      if (nbits != 0 && nbits < 6) begin
        t = bits << (6 - nbits);
        put(sextet_char(t[5:0]));
      end
      put(CH_DASH);
      shifted = 0;
      nbits   = '0;
      seq_len = '0;
      seq_pos = '0;
    endfunction

    function void push_unit(logic [15:0] u);
      logic [19:0] t;
      bits  = {bits[3:0], u};
      nbits = nbits + 5'd16;
      while (nbits >= 6) begin
        nbits = nbits - 5'd6;
        t = bits >> nbits;
        put(sextet_char(t[5:0]));
      end
    endfunction

    function void encode_item(logic [7:0] c, bit eos);
      bit          done;
      logic [20:0] v;
      logic [20:0] hi;
      enc_char_t   e;
      step_chars.delete();
      if (eos) begin
        if (shifted) close_run();
        clear_state();
      end else if (c >= BYTE_SPACE && c <= BYTE_TILDE && (c != BYTE_UNDERSCORE || !spaces)) begin
        if (shifted) close_run();
        put((spaces && c == BYTE_SPACE) ? CH_UNDERSCORE : c[6:0]);
        if (c[6:0] == CH_AMP) put(CH_DASH);
      end else begin
        done = 1;
        if (!shifted) begin
          put(CH_AMP);
          shifted = 1;
        end
        if (c < BYTE_HIGH) begin
          cp = {13'd0, c};
        end else if (seq_len != 0) begin
          // A lead byte inside an open sequence is taken as a continuation too.
          cp = {cp[14:0], c[5:0]};
          seq_pos = seq_pos + 3'd1;
          if (seq_pos < seq_len) done = 0;
        end else begin
          seq_pos = 3'd1;
          if (c < BYTE_LEAD3) begin
            seq_len = 3'd2;
            cp = {16'd0, c[4:0]};
          end else if (c < BYTE_LEAD4) begin
            seq_len = 3'd3;
            cp = {17'd0, c[3:0]};
          end else begin
            seq_len = 3'd4;
            cp = {18'd0, c[2:0]};
          end
          done = 0;
        end
        if (done) begin
          seq_len = '0;
          if (cp >= CP_SUPPLEMENTARY) begin
            v  = cp - CP_SUPPLEMENTARY;
            hi = (v >> 10) + SURR_HIGH_BASE;
            push_unit(hi[15:0]);
            push_unit({6'd0, v[9:0]} + SURR_LOW_BASE);
          end else begin
            push_unit(cp[15:0]);
          end
        end
      end
      foreach (step_chars[k]) begin
        e.ch  = step_chars[k];
        e.fin = (k == step_chars.size() - 1);
        owed_q.push_back(e);
      end
    endfunction

    function void check_char(logic [7:0] data, logic fin);
      enc_char_t e;
      if (owed_q.size() == 0) begin
        $error("out_char: beat with nothing expected, actual %h", data);
        failures++;
        return;
      end
      e = owed_q.pop_front();
      if (data !== {1'b0, e.ch}) begin
        $error("out_char: expected %h, actual %h", {1'b0, e.ch}, data);
        failures++;
      end
      if (fin !== e.fin) begin
        $error("last: expected %b, actual %b", e.fin, fin);
        failures++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic [0:0] in_tuser;   // [0] end_of_string
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [6:0] out_char, [7] zero
  logic       out_tlast;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  bit          sender_gaps;
  bit          sink_stalls;
  int          cycles;
  utf7_checker sb = new();

  modified_utf7_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eos);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = eos;
    do @(posedge clk); while (!in_tready);
    sb.encode_item(b, eos);
    @(negedge clk);
  endtask

  // Stop sending and let every owed character come out, plus a margin for result-free items.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_spaces(input bit v);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.spaces = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_phase(input int count, input int hold_at);
    int         sent;
    int         r;
    int         len;
    logic [7:0] b;
    sent = 0;
    while (sent < count) begin
      if (hold_at >= 0 && sent >= hold_at) begin
        wait_idle();
        hold_at = -1;
      end
      r = $urandom_range(0, 99);
      if (r < 35) begin
        // Lead byte and its continuation bytes with random payload (not always well-formed UTF-8).
        len = $urandom_range(2, 4);
        case (len)
          2: b = 8'hC0 | 8'($urandom_range(0, 31));
          3: b = 8'hE0 | 8'($urandom_range(0, 15));
          default: b = 8'hF0 | 8'($urandom_range(0, 15));
        endcase
        send_item(b, 1'b0);
        sent++;
        repeat (len - 1) begin
          b = 8'h80 | 8'($urandom_range(0, 63));
          send_item(b, 1'b0);
          sent++;
        end
      end else if (r < 65) begin
        case ($urandom_range(0, 7))
          0: b = BYTE_SPACE;
          1: b = BYTE_UNDERSCORE;
          2: b = {1'b0, CH_AMP};
          default: b = 8'($urandom_range(32, 126));
        endcase
        send_item(b, 1'b0);
        sent++;
      end else if (r < 75) begin
        len = $urandom_range(0, 32);
        b = (len == 32) ? 8'h7F : 8'(len);
        send_item(b, 1'b0);
        sent++;
      end else if (r < 83) begin
        b = 8'($urandom_range(0, 255));
        send_item(b, 1'b1);
        sent++;
      end else begin
        // Stray continuation or lead bytes that break sequences.
        b = 8'($urandom_range(128, 255));
        send_item(b, 1'b0);
        sent++;
      end
    end
  endtask

  initial begin : sink_driver
    int stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
        if (sink_stalls && $urandom_range(0, 4) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_char(out_tdata, out_tlast);
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("modified_utf7_encoder_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    int i;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_valid   = 1'b0;
    cfg_data    = 1'b0;
    rst_n       = 1'b0;
    sender_gaps = 1;
    sink_stalls = 1;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Direct characters, ampersand escape, and an end item with nothing to flush.
    send_item(8'h41, 1'b0);
    send_item(8'h26, 1'b0);
    send_item(8'h20, 1'b0);
    send_item(8'h7E, 1'b0);
    send_item(8'h5F, 1'b0);
    send_item(8'h00, 1'b1);
    // NUL and a control byte in base64, then a printable byte closes the run.
    send_item(8'h00, 1'b0);
    send_item(8'h1F, 1'b0);
    send_item(8'h78, 1'b0);
    // Two- and four-byte sequences, then an end item with an ignored byte.
    send_item(8'hC3, 1'b0);
    send_item(8'hA9, 1'b0);
    send_item(8'hF0, 1'b0);
    send_item(8'h9F, 1'b0);
    send_item(8'h98, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b1);
    // Stray continuation acting as a lead.
    send_item(8'h85, 1'b0);
    send_item(8'h80, 1'b0);
    // Code point beyond the Unicode range from a 0xF8..0xFF lead.
    send_item(8'hFF, 1'b0);
    send_item(8'hBF, 1'b0);
    send_item(8'hBF, 1'b0);
    send_item(8'hBF, 1'b0);
    // A surrogate value reached by a three-byte sequence.
    send_item(8'hED, 1'b0);
    send_item(8'hA0, 1'b0);
    send_item(8'h80, 1'b0);
    // Sequences cut short by a printable byte, by a control byte and by an end item.
    send_item(8'hE2, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'hE2, 1'b0);
    send_item(8'h07, 1'b0);
    send_item(8'hC3, 1'b0);
    send_item(8'hE2, 1'b0);
    send_item(8'hF0, 1'b0);
    send_item(8'h9F, 1'b1);

    write_spaces(1'b1);
    send_item(8'h20, 1'b0);
    send_item(8'h5F, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h00, 1'b1);

    for (i = 0; i < 4; i++) begin
      write_spaces(i[0] ? 1'b0 : 1'b1);
      sender_gaps = (i == 0 || i == 2);
      sink_stalls = (i == 0 || i == 3);
      random_phase(30, (i == 2) ? 15 : -1);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.waiting() == 0) begin
      $display("modified_utf7_encoder_test: done, clean");
    end else begin
      $display("modified_utf7_encoder_test: done, errors");
    end
    $finish;
  end

endmodule
